// ----- hw/rtl/multi_key_click_long_press_detector_defines.svh -----
// Assertion macros for the key detector.
`ifndef MULTI_KEY_CLICK_LONG_PRESS_DETECTOR_DEFINES_SVH
`define MULTI_KEY_CLICK_LONG_PRESS_DETECTOR_DEFINES_SVH

// same-cycle implication
`define MKCLPD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MKCLPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mkclpd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mkclpd_pkg;

    localparam int MAX_KEYS   = 5;
    localparam int EVENTS_W   = 2 * MAX_KEYS;
    localparam int ELAPSED_W  = 10;
    localparam int REL_CNT_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int SHORT_W    = 8;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MASK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_DB    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DB  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_SCANS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DBL_WINDOW  = 3'd5;

    localparam logic [SHORT_W-1:0]   RST_PRESS_DB   = 8'd1;
    localparam logic [SHORT_W-1:0]   RST_RELEASE_DB = 8'd2;
    localparam logic [ELAPSED_W-1:0] RST_LONG_SCANS = 10'd300;
    localparam logic [SHORT_W-1:0]   RST_DBL_WINDOW = 8'd20;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_CLICK  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } event_t;

    typedef struct packed {
        logic [SHORT_W-1:0]   press_db;
        logic [SHORT_W-1:0]   release_db;
        logic [ELAPSED_W-1:0] long_scans;
        logic [SHORT_W-1:0]   dbl_window;
    } timing_t;

    typedef struct packed {
        logic scan;
        logic clear;
        logic pressed;
        logic dbl_en;
        logic lng_en;
    } key_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mkclpd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface mkclpd_req_if;
    import mkclpd_pkg::*;
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [MAX_KEYS-1:0] key_levels;
    modport source (output valid, output req_type, output key_levels, input ready);
    modport sink   (input valid, input req_type, input key_levels, output ready);
endinterface

interface mkclpd_rsp_if;
    import mkclpd_pkg::*;
    logic                valid;
    logic                ready;
    logic [EVENTS_W-1:0] events_packed;
    modport source (output valid, output events_packed, input ready);
    modport sink   (input valid, input events_packed, output ready);
endinterface

interface mkclpd_cfg_if;
    import mkclpd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mkclpd_key.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mkclpd_key (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire mkclpd_pkg::key_ctl_t ctl,
    input  wire mkclpd_pkg::timing_t  timing,
    output mkclpd_pkg::event_t   pending
);
    import mkclpd_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE        = 6'b000001,
        ST_DEBOUNCE    = 6'b000010,
        ST_PRESSED     = 6'b000100,
        ST_REL_DEBOUNCE = 6'b001000,
        ST_WAIT_DOUBLE = 6'b010000,
        ST_LONG        = 6'b100000
    } key_state_t;

    key_state_t           state_reg, state_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next, elapsed_inc;
    event_t               event_reg, event_next;
    logic [REL_CNT_W-1:0] rel_cnt_reg, rel_cnt_next;

    logic press_done, rel_done, long_done, window_done;

    assign elapsed_inc = (elapsed_reg < ELAPSED_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign press_done  = elapsed_inc >= {{(ELAPSED_W-SHORT_W){1'b0}}, timing.press_db};
    assign rel_done    = elapsed_inc >= {{(ELAPSED_W-SHORT_W){1'b0}}, timing.release_db};
    assign long_done   = elapsed_inc >= timing.long_scans;
    assign window_done = elapsed_inc >= {{(ELAPSED_W-SHORT_W){1'b0}}, timing.dbl_window};

    always_comb
    begin
        state_next   = state_reg;
        elapsed_next = elapsed_reg;
        event_next   = ctl.clear ? EV_NONE : event_reg;
        rel_cnt_next = rel_cnt_reg;
        if (ctl.scan)
        begin
            elapsed_next = elapsed_inc;
            case (state_reg)
                ST_DEBOUNCE:
                begin
                    if (press_done)
                    begin
                        if (ctl.pressed)
                        begin
                            state_next   = ST_PRESSED;
                            elapsed_next = '0;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                ST_PRESSED:
                begin
                    if (ctl.pressed)
                    begin
                        if (ctl.lng_en && long_done)
                        begin
                            event_next   = EV_LONG;
                            rel_cnt_next = '0;
                            state_next   = ST_LONG;
                        end
                    end
                    else
                    begin
                        state_next   = ST_REL_DEBOUNCE;
                        elapsed_next = '0;
                    end
                end
                ST_REL_DEBOUNCE:
                begin
                    if (rel_done)
                    begin
                        if (ctl.pressed)
                        begin
                            state_next   = ST_DEBOUNCE;
                            elapsed_next = '0;
                        end
                        else if (!ctl.dbl_en)
                        begin
                            event_next   = EV_CLICK;
                            rel_cnt_next = '0;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            if (rel_cnt_reg < 2'd2)
                            begin
                                rel_cnt_next = rel_cnt_reg + 1'b1;
                            end
                            state_next   = ST_WAIT_DOUBLE;
                            elapsed_next = '0;
                        end
                    end
                end
                ST_WAIT_DOUBLE:
                begin
                    if (ctl.pressed)
                    begin
                        state_next   = ST_DEBOUNCE;
                        elapsed_next = '0;
                    end
                    else if (window_done)
                    begin
                        event_next   = (rel_cnt_reg >= 2'd2) ? EV_DOUBLE : EV_CLICK;
                        rel_cnt_next = '0;
                        state_next   = ST_IDLE;
                    end
                end
                ST_LONG:
                begin
                    if (!ctl.pressed)
                    begin
                        rel_cnt_next = '0;
                        state_next   = ST_IDLE;
                    end
                end
                default:
                begin
                    if (ctl.pressed)
                    begin
                        state_next   = ST_DEBOUNCE;
                        elapsed_next = '0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            elapsed_reg <= '0;
            event_reg   <= EV_NONE;
            rel_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            event_reg   <= event_next;
            rel_cnt_reg <= rel_cnt_next;
        end
    end

    assign pending = event_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/multi_key_click_long_press_detector.sv -----
// Scan and read transactions are accepted one per clock cycle; a read waits
// in the input register only while an earlier result is still not taken.
// A read result passes through the input register, then the result register,
// before it is valid; scans produce no result.
// rst_n (async, active low): every key idle, counts zero, no pending events;
// masks 0, press debounce 1, release debounce 2, long press 300, window 20 scans.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_key_click_long_press_detector_defines.svh"

module multi_key_click_long_press_detector #(
    parameter int NUM_KEYS = mkclpd_pkg::MAX_KEYS
) (
    input wire           clk,
    input wire           rst_n,
    mkclpd_req_if.sink   req,
    mkclpd_rsp_if.source rsp,
    mkclpd_cfg_if.sink   cfg
);
    import mkclpd_pkg::*;

    // configuration
    logic [MAX_KEYS-1:0] dbl_mask_reg;
    logic [MAX_KEYS-1:0] lng_mask_reg;
    timing_t             timing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbl_mask_reg          <= '0;
            lng_mask_reg          <= '0;
            timing_reg.press_db   <= RST_PRESS_DB;
            timing_reg.release_db <= RST_RELEASE_DB;
            timing_reg.long_scans <= RST_LONG_SCANS;
            timing_reg.dbl_window <= RST_DBL_WINDOW;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DOUBLE_MASK: dbl_mask_reg          <= cfg.data[MAX_KEYS-1:0];
                REG_LONG_MASK:   lng_mask_reg          <= cfg.data[MAX_KEYS-1:0];
                REG_PRESS_DB:    timing_reg.press_db   <= cfg.data[SHORT_W-1:0];
                REG_RELEASE_DB:  timing_reg.release_db <= cfg.data[SHORT_W-1:0];
                REG_LONG_SCANS:  timing_reg.long_scans <= cfg.data[ELAPSED_W-1:0];
                REG_DBL_WINDOW:  timing_reg.dbl_window <= cfg.data[SHORT_W-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // input register
    logic                s1_valid_reg;
    logic                s1_type_reg;
    logic [MAX_KEYS-1:0] s1_levels_reg;
    logic                s1_fire;
    logic                out_free;

    logic                out_valid_reg;
    logic [EVENTS_W-1:0] out_events_reg;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_fire   = s1_valid_reg && ((s1_type_reg == REQ_SCAN) || out_free);
    assign req.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_type_reg   <= req.req_type;
            s1_levels_reg <= req.key_levels;
        end
    end

    // key machines
    logic [EVENTS_W-1:0] events_all;
    logic                do_scan;
    logic                do_read;

    assign do_scan = s1_fire && (s1_type_reg == REQ_SCAN);
    assign do_read = s1_fire && (s1_type_reg == REQ_READ);

    for (genvar k = 0; k < MAX_KEYS; k++)
    begin : g_key
        if (k < NUM_KEYS)
        begin : g_used
            key_ctl_t ctl;
            event_t   ev;

            assign ctl.scan    = do_scan;
            assign ctl.clear   = do_read;
            assign ctl.pressed = !s1_levels_reg[k];
            assign ctl.dbl_en  = dbl_mask_reg[k];
            assign ctl.lng_en  = lng_mask_reg[k];

            mkclpd_key u_key (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .timing  (timing_reg),
                .pending (ev)
            );

            assign events_all[2*k+1:2*k] = ev;
        end
        else
        begin : g_unused
            assign events_all[2*k+1:2*k] = EV_NONE;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= do_read;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_read)
        begin
            out_events_reg <= events_all;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.events_packed = out_events_reg;

    `MKCLPD_ASSERT_NEXT(a_read_loads_result, clk, rst_n, do_read, out_valid_reg, "read lost")
    `MKCLPD_ASSERT_NEXT(a_read_clears, clk, rst_n, do_read, events_all == '0, "events not cleared")
    `MKCLPD_ASSERT_SAME(a_unused_keys_zero, clk, rst_n, out_valid_reg, (out_events_reg >> (2*NUM_KEYS)) == '0, "unused key event")
    `MKCLPD_ASSERT_SAME(a_stall_only_full, clk, rst_n, !req.ready, s1_valid_reg && out_valid_reg, "spurious stall")

endmodule

`default_nettype wire
